// ===== rtl/pm_pkg.sv =====
// ----------------------------------------------------------------------------
// pm_pkg
// Shared types and fixed widths for the polynomial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package pm_pkg;

   // fixed widths of the result fields
   localparam int TERM_W  = 37;
   localparam int POWER_W = 6;

   // request action codes
   localparam logic ACT_FIRST  = 1'b0;
   localparam logic ACT_SECOND = 1'b1;

   // control states of the top level
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   // status from the convolution engine
   typedef struct packed {
      logic busy;
      logic done;
   } conv_status_type;

endpackage

`default_nettype wire

// ===== rtl/polynomial_multiply.sv =====
// Each accepted request carries one coefficient; the request that closes the second operand
// starts the multiply. Convolution: one coefficient pair per cycle, through a read, multiply
// and accumulate pipeline (one product memory write port).
// Emission: one product term read in flight on the product memory at a time.
// Reset is synchronous and clears counts, flags and control; the coefficient and product
// memories are not cleared, since every entry is written before it is read.
`default_nettype none

module polynomial_multiply
   import pm_pkg::*;
#(
   parameter int MAX_TERMS  = 32,
   parameter int COEFF_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic                    req_action,
   input  wire logic [COEFF_BITS-1:0]   req_coefficient,
   input  wire logic                    req_last,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [TERM_W-1:0]       rsp_product_term,
   output      logic [POWER_W-1:0]      rsp_power,
   output      logic                    rsp_overflow,
   output      logic                    rsp_final_res
);

   localparam int CW    = $clog2(MAX_TERMS + 1);
   localparam int IW    = $clog2(MAX_TERMS);
   localparam int PLEN  = 2 * MAX_TERMS - 1;
   localparam int PW    = $clog2(PLEN);

   state_type state_ff, state_in;

   logic [CW-1:0] fc_ff, fc_in, sc_ff, sc_in;
   logic          closed_ff, closed_in;
   logic          dropped_ff, dropped_in;
   logic          launch_ff;

   logic          req_accept, rsp_accept, trigger, finish;
   logic [CW-1:0] fc_eff;
   logic          first_we, second_we;

   logic [IW-1:0]           first_rd_addr, second_rd_addr;
   logic [COEFF_BITS-1:0]   first_rd_data, second_rd_data;
   logic                    prod_we;
   logic [PW-1:0]           prod_wr_addr, top_power;
   logic [TERM_W-1:0]       prod_wr_data, prod_rd_data;
   conv_status_type         conv_status;

   logic          issue, issue_final;
   logic [PW-1:0] e_ff;
   logic          last_issued_ff;
   logic          pend_ff, pend_final_ff;
   logic [PW-1:0] pend_k_ff;

   logic              rsp_valid_ff;
   logic [TERM_W-1:0] term_ff;
   logic [PW-1:0]     out_k_ff;
   logic              out_final_ff;

   // handshake events
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign trigger    = req_accept && (req_action == ACT_SECOND) && req_last;
   assign finish     = rsp_accept && out_final_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (trigger) state_in = ST_CONV;
         ST_CONV: if (conv_status.done) state_in = ST_EMIT;
         ST_EMIT: if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      issue       = (state_ff == ST_EMIT) && !pend_ff && !last_issued_ff &&
                    (!rsp_valid_ff || !rsp_stall);
      issue_final = (e_ff == top_power);
   end

   // operand loading and counts
   always_comb begin
      fc_eff     = closed_ff ? '0 : fc_ff;
      fc_in      = fc_ff;
      sc_in      = sc_ff;
      closed_in  = closed_ff;
      dropped_in = dropped_ff;
      first_we   = 1'b0;
      second_we  = 1'b0;
      if (finish) begin
         fc_in      = '0;
         sc_in      = '0;
         closed_in  = 1'b0;
         dropped_in = 1'b0;
      end else if (req_accept) begin
         if (req_action == ACT_FIRST) begin
            if (fc_eff < CW'(MAX_TERMS)) begin
               first_we = 1'b1;
               fc_in    = fc_eff + CW'(1);
            end else begin
               fc_in      = fc_eff;
               dropped_in = 1'b1;
            end
            closed_in = req_last;
         end else begin
            if (sc_ff < CW'(MAX_TERMS)) begin
               second_we = 1'b1;
               sc_in     = sc_ff + CW'(1);
            end else begin
               dropped_in = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fc_ff          <= '0;
         sc_ff          <= '0;
         closed_ff      <= 1'b0;
         dropped_ff     <= 1'b0;
         launch_ff      <= 1'b0;
         last_issued_ff <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         e_ff           <= '0;
      end else begin
         state_ff   <= state_in;
         fc_ff      <= fc_in;
         sc_ff      <= sc_in;
         closed_ff  <= closed_in;
         dropped_ff <= dropped_in;
         launch_ff  <= trigger;
         pend_ff    <= issue;
         if (state_ff != ST_EMIT) begin
            e_ff           <= '0;
            last_issued_ff <= 1'b0;
         end else if (issue) begin
            e_ff           <= e_ff + PW'(1);
            last_issued_ff <= issue_final;
         end
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (issue) begin
         pend_k_ff     <= e_ff;
         pend_final_ff <= issue_final;
      end
      if (pend_ff) begin
         term_ff      <= prod_rd_data;
         out_k_ff     <= pend_k_ff;
         out_final_ff <= pend_final_ff;
      end
   end

   // operand memories
   pm_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_TERMS)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (fc_eff[IW-1:0]),
      .wr_data (req_coefficient),
      .rd_addr (first_rd_addr),
      .rd_data (first_rd_data)
   );

   pm_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_TERMS)) u_second_ram (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (sc_ff[IW-1:0]),
      .wr_data (req_coefficient),
      .rd_addr (second_rd_addr),
      .rd_data (second_rd_data)
   );

   // convolution engine
   pm_conv #(.MAX_TERMS(MAX_TERMS), .COEFF_BITS(COEFF_BITS)) u_conv (
      .clock        (clock),
      .reset        (reset),
      .start        (launch_ff),
      .first_count  (fc_ff),
      .second_count (sc_ff),
      .first_addr   (first_rd_addr),
      .second_addr  (second_rd_addr),
      .first_data   (first_rd_data),
      .second_data  (second_rd_data),
      .prod_wr_en   (prod_we),
      .prod_wr_addr (prod_wr_addr),
      .prod_wr_data (prod_wr_data),
      .top_power    (top_power),
      .status       (conv_status)
   );

   // product memory
   pm_ram #(.WIDTH(TERM_W), .DEPTH(PLEN)) u_prod_ram (
      .clock   (clock),
      .wr_en   (prod_we),
      .wr_addr (prod_wr_addr),
      .wr_data (prod_wr_data),
      .rd_addr (e_ff),
      .rd_data (prod_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_product_term = term_ff;
   assign rsp_power        = POWER_W'(out_k_ff);
   assign rsp_overflow     = dropped_ff;
   assign rsp_final_res    = out_final_ff;

endmodule

`default_nettype wire

// ===== rtl/pm_ram.sv =====
// ----------------------------------------------------------------------------
// pm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/pm_conv.sv =====
// ----------------------------------------------------------------------------
// pm_conv
// Convolution engine: walks the coefficient pairs one per cycle, grouped by
// output power, multiplies and accumulates, and writes each finished sum into
// the product memory while tracking the highest non-zero power.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_conv
   import pm_pkg::*;
#(
   parameter int MAX_TERMS  = 32,
   parameter int COEFF_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [$clog2(MAX_TERMS+1)-1:0]        first_count,
   input  wire logic [$clog2(MAX_TERMS+1)-1:0]        second_count,
   output      logic [$clog2(MAX_TERMS)-1:0]          first_addr,
   output      logic [$clog2(MAX_TERMS)-1:0]          second_addr,
   input  wire logic [COEFF_BITS-1:0]                 first_data,
   input  wire logic [COEFF_BITS-1:0]                 second_data,
   output      logic                                  prod_wr_en,
   output      logic [$clog2(2*MAX_TERMS-1)-1:0]      prod_wr_addr,
   output      logic [TERM_W-1:0]                     prod_wr_data,
   output      logic [$clog2(2*MAX_TERMS-1)-1:0]      top_power,
   output      conv_status_type                       status
);

   localparam int CW     = $clog2(MAX_TERMS + 1);
   localparam int IW     = $clog2(MAX_TERMS);
   localparam int PW     = $clog2(2 * MAX_TERMS - 1);
   localparam int PROD_W = 2 * COEFF_BITS;

   // pair walker
   logic          run_ff, run_in;
   logic          zero_ff, zero_in;
   logic [IW-1:0] is_ff, is_in, js_ff, js_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [PW-1:0] k_ff, k_in;

   // pipeline stage after the memory read
   logic          v1_ff, first1_ff, lastk1_ff, fin1_ff;
   logic [PW-1:0] k1_ff;

   // pipeline stage after the multiply
   logic                     v2_ff, first2_ff, lastk2_ff, fin2_ff;
   logic [PW-1:0]            k2_ff;
   logic signed [PROD_W-1:0] mul_ff;

   // accumulator and results
   logic [TERM_W-1:0] acc_ff, acc_in;
   logic [PW-1:0]     top_ff, top_in;
   logic              done_ff, done_in;

   logic i_top, j_top, js_top, lastk, fin;

   // pair walk decode
   always_comb begin
      i_top  = (CW'(i_ff) + CW'(1)) == first_count;
      j_top  = (CW'(j_ff) + CW'(1)) == second_count;
      js_top = (CW'(js_ff) + CW'(1)) == second_count;
      lastk  = i_top || (j_ff == '0);
      fin    = i_top && j_top;
   end

   assign first_addr  = i_ff;
   assign second_addr = j_ff;

   // next pair: along the anti-diagonal, then to the start of the next power
   always_comb begin
      run_in  = run_ff;
      zero_in = 1'b0;
      is_in   = is_ff;
      js_in   = js_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      if (start) begin
         if (first_count == '0) begin
            zero_in = 1'b1;
         end else begin
            run_in = 1'b1;
         end
         is_in = '0;
         js_in = '0;
         i_in  = '0;
         j_in  = '0;
         k_in  = '0;
      end else if (run_ff) begin
         if (fin) begin
            run_in = 1'b0;
         end else if (lastk) begin
            if (!js_top) begin
               js_in = js_ff + IW'(1);
               i_in  = is_ff;
               j_in  = js_ff + IW'(1);
            end else begin
               is_in = is_ff + IW'(1);
               i_in  = is_ff + IW'(1);
               j_in  = js_ff;
            end
            k_in = k_ff + PW'(1);
         end else begin
            i_in = i_ff + IW'(1);
            j_in = j_ff - IW'(1);
         end
      end
   end

   // accumulate the registered product
   always_comb begin
      acc_in = (first2_ff ? '0 : acc_ff) + TERM_W'(mul_ff);
   end

   // product memory write and highest non-zero power
   always_comb begin
      prod_wr_en   = (v2_ff && lastk2_ff) || zero_ff;
      prod_wr_addr = zero_ff ? '0 : k2_ff;
      prod_wr_data = zero_ff ? '0 : acc_in;
      top_in       = top_ff;
      if (start) begin
         top_in = '0;
      end else if (v2_ff && lastk2_ff && (acc_in != '0)) begin
         top_in = k2_ff;
      end
      done_in = (v2_ff && fin2_ff) || zero_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         zero_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         zero_ff <= zero_in;
         v1_ff   <= run_ff;
         v2_ff   <= v1_ff;
         done_ff <= done_in;
      end
   end

   // walker indexes, pipeline payload and accumulator
   always_ff @(posedge clock) begin
      is_ff     <= is_in;
      js_ff     <= js_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      first1_ff <= (i_ff == is_ff);
      lastk1_ff <= lastk;
      fin1_ff   <= fin;
      k1_ff     <= k_ff;
      first2_ff <= first1_ff;
      lastk2_ff <= lastk1_ff;
      fin2_ff   <= fin1_ff;
      k2_ff     <= k1_ff;
      mul_ff    <= $signed(first_data) * $signed(second_data);
      top_ff    <= top_in;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign top_power   = top_ff;
   assign status.busy = run_ff || v1_ff || v2_ff || zero_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/pm_check.sv =====
// ----------------------------------------------------------------------------
// pm_check
// Port-level checks for the polynomial multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_check
   import pm_pkg::*;
#(
   parameter int COEFF_BITS = 16
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    req_action,
   input wire logic [COEFF_BITS-1:0]   req_coefficient,
   input wire logic                    req_last,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic [TERM_W-1:0]       rsp_product_term,
   input wire logic [POWER_W-1:0]      rsp_power,
   input wire logic                    rsp_overflow,
   input wire logic                    rsp_final_res
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product_term) &&
      $stable(rsp_power) && $stable(rsp_final_res) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // no request is taken while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted during result delivery");

   // the request that closes the second operand starts the multiply
   a_launch: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_SECOND) && req_last |=> req_stall)
      else $error("multiply did not start");

   // nothing follows the final term
   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_final_res |=> !rsp_valid)
      else $error("result after final term");

   // a stalled request holds its coefficient, action and last flag
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_coefficient) &&
      $stable(req_action) && $stable(req_last))
      else $error("stalled request changed");

endmodule

bind polynomial_multiply pm_check #(.COEFF_BITS(COEFF_BITS)) u_pm_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_action       (req_action),
   .req_coefficient  (req_coefficient),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_product_term (rsp_product_term),
   .rsp_power        (rsp_power),
   .rsp_overflow     (rsp_overflow),
   .rsp_final_res    (rsp_final_res)
);

`default_nettype wire
